### design/checksum_frame_verifier_macros.svh
// Assertion macros shared by the checksum frame verifier checkers.
`ifndef CHECKSUM_FRAME_VERIFIER_MACROS_SVH
`define CHECKSUM_FRAME_VERIFIER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CFV_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CFV_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/cfv_pkg.sv
// Shared types, constants and the end-around adder of the checksum frame verifier.
package cfv_pkg;

    // Header is payload length (2 bytes) then checksum (2 bytes), little-endian.
    localparam logic [2:0] HEADER_BYTES = 3'd4;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_SHORT   = 2'd1,
        STATUS_BAD_SUM = 2'd2
    } status_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] computed_checksum;
        logic [15:0] frame_length;
    } cfv_result_t;

    // 16-bit ones' complement add: carry out wraps back into bit 0.
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'h0000, s[16]};
    endfunction

endpackage

### design/cfv_if.sv
// Valid/ready channel interfaces for the byte stream and the frame report.
interface cfv_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       buffer_end;

    modport source (output valid, output data_byte, output buffer_end, input ready);
    modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface cfv_report_if;
    logic              valid;
    logic              ready;
    cfv_pkg::status_t  status;
    logic [15:0]       computed_checksum;
    logic [15:0]       frame_length;

    modport source (output valid, output status, output computed_checksum,
                    output frame_length, input ready);
    modport sink   (input valid, input status, input computed_checksum,
                    input frame_length, output ready);
endinterface

### design/cfv_frame_core.sv
// Frame state and checksum datapath: one byte per step, one end-around add.
module cfv_frame_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           data_byte,
    input  logic                 buffer_end,
    output logic                 emit,
    output cfv_pkg::cfv_result_t result
);

    logic [2:0]  hdr_count_reg, hdr_count_next;
    logic [15:0] plen_reg, plen_next;
    logic [15:0] exp_reg, exp_next;
    logic [15:0] sum_reg, sum_next;
    logic [15:0] seen_reg, seen_next;
    logic [7:0]  pend_reg, pend_next;
    logic        payload_phase;
    logic        complete;
    logic [15:0] addend;
    logic [15:0] sum_add;
    logic [15:0] chk;

    assign payload_phase = (hdr_count_reg == cfv_pkg::HEADER_BYTES);

    // Odd byte: pad with zero so the add also gives the final sum;
    // even byte: completes the word with the pending low byte.
    always_comb
    begin
        if (!payload_phase)
            addend = 16'h0000;
        else if (seen_reg[0])
            addend = {data_byte, pend_reg};
        else
            addend = {8'h00, data_byte};
    end

    assign sum_add = cfv_pkg::ones_add(sum_reg, addend);
    assign chk     = ~sum_add;

    always_comb
    begin
        hdr_count_next = hdr_count_reg;
        plen_next      = plen_reg;
        exp_next       = exp_reg;
        sum_next       = sum_reg;
        seen_next      = seen_reg;
        pend_next      = pend_reg;
        complete       = 1'b0;
        if (!payload_phase)
        begin
            case (hdr_count_reg[1:0])
                2'd0:    plen_next[7:0]  = data_byte;
                2'd1:    plen_next[15:8] = data_byte;
                2'd2:    exp_next[7:0]   = data_byte;
                default: exp_next[15:8]  = data_byte;
            endcase
            hdr_count_next = hdr_count_reg + 3'd1;
            complete = (hdr_count_next == cfv_pkg::HEADER_BYTES) && (plen_reg == 16'h0000);
        end
        else
        begin
            if (seen_reg[0])
                sum_next = sum_add;
            else
                pend_next = data_byte;
            seen_next = seen_reg + 16'd1;
            complete  = (seen_next == plen_reg);
        end
    end

    assign emit = complete || buffer_end;

    always_comb
    begin
        result.computed_checksum = chk;
        result.frame_length      = plen_next;
        if (!complete)
            result.status = cfv_pkg::STATUS_SHORT;
        else if (chk == exp_next)
            result.status = cfv_pkg::STATUS_OK;
        else
            result.status = cfv_pkg::STATUS_BAD_SUM;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_count_reg <= '0;
            plen_reg      <= '0;
            exp_reg       <= '0;
            sum_reg       <= '0;
            seen_reg      <= '0;
            pend_reg      <= '0;
        end
        else if (step)
        begin
            if (emit)
            begin
                // Report issued: wait for a fresh frame.
                hdr_count_reg <= '0;
                plen_reg      <= '0;
                exp_reg       <= '0;
                sum_reg       <= '0;
                seen_reg      <= '0;
                pend_reg      <= '0;
            end
            else
            begin
                hdr_count_reg <= hdr_count_next;
                plen_reg      <= plen_next;
                exp_reg       <= exp_next;
                sum_reg       <= sum_next;
                seen_reg      <= seen_next;
                pend_reg      <= pend_next;
            end
        end
    end

endmodule

### design/checksum_frame_verifier.sv
// Top level of the checksum frame verifier: input stage, frame core, report register.
// Checks frames of the form length (2 bytes, LE), checksum (2 bytes, LE), payload,
// against the inverted 16-bit ones' complement sum of the payload (bytes paired low
// then high, odd last byte padded with zero). One byte is taken per cycle on the
// frame channel, sustained, as long as the report channel is not stalled. A byte
// is registered in the input stage on acceptance and moves into the frame core when
// the report register has room; the report is then registered in the report register
// from the byte that closed the frame (a completed payload, a zero-length header, or a
// byte flagged buffer_end).
// Status: ok, not enough data (buffer ended first), or invalid checksum. A byte
// that completes the frame and also carries buffer_end is reported as complete.
// After each report the block expects a new header. frame.ready follows
// report.ready combinationally whenever a byte waits in the input stage while a
// report is held in the output register.
module checksum_frame_verifier (
    input logic          clk,
    input logic          rst_n,
    cfv_byte_if.sink     frame,
    cfv_report_if.source report
);

    // Input stage
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Report register
    logic                 out_valid_reg, out_valid_next;
    cfv_pkg::cfv_result_t out_reg;

    logic                 advance;
    logic                 emit;
    cfv_pkg::cfv_result_t result;

    // The held byte moves into the core when the report register has room;
    // an item that yields no report still needs that room so nothing is lost.
    assign advance     = in_valid_reg && (!out_valid_reg || report.ready);
    assign frame.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (frame.ready)
            in_valid_reg <= frame.valid;
    end

    always_ff @(posedge clk)
    begin
        if (frame.valid && frame.ready)
        begin
            in_byte_reg <= frame.data_byte;
            in_last_reg <= frame.buffer_end;
        end
    end

    cfv_frame_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .data_byte  (in_byte_reg),
        .buffer_end (in_last_reg),
        .emit       (emit),
        .result     (result)
    );

    // A report held in the report register stays until taken.
    assign out_valid_next = (out_valid_reg && !report.ready) || (advance && emit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
            out_reg <= result;
    end

    assign report.valid             = out_valid_reg;
    assign report.status            = out_reg.status;
    assign report.computed_checksum = out_reg.computed_checksum;
    assign report.frame_length      = out_reg.frame_length;

endmodule

### design/cfv_checker.sv
// Port-level checks of the checksum frame verifier, bound to the top level.
`include "checksum_frame_verifier_macros.svh"

module cfv_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        frame_valid,
    input logic        frame_ready,
    input logic        report_valid,
    input logic        report_ready,
    input logic [1:0]  status,
    input logic [15:0] computed_checksum,
    input logic [15:0] frame_length
);

    `CFV_ASSERT_NXT(a_report_hold, report_valid && !report_ready, report_valid && $stable({status, computed_checksum, frame_length}), "stalled report changed")
    `CFV_ASSERT_IMP(a_no_stall, report_ready || !report_valid, frame_ready, "input stalled with free report slot")
    `CFV_ASSERT_IMP(a_report_latency, $rose(report_valid), $past(frame_valid && frame_ready, 2), "report without byte two cycles before")
    `CFV_ASSERT_IMP(a_empty_sum, report_valid && (frame_length == 16'h0000), computed_checksum == 16'hffff, "empty payload checksum not all ones")

endmodule

bind checksum_frame_verifier cfv_checker u_cfv_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .frame_valid       (frame.valid),
    .frame_ready       (frame.ready),
    .report_valid      (report.valid),
    .report_ready      (report.ready),
    .status            (report.status),
    .computed_checksum (report.computed_checksum),
    .frame_length      (report.frame_length)
);

### dv/tb.sv
// Self-checking testbench for the checksum frame verifier: directed frames, then random traffic.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [7:0] byte_q_t[$];

    // Random traffic volume, and the point after which both sides stop idling.
    localparam int RANDOM_BYTES   = 2000;
    localparam int CALM_FROM      = 1700;
    // Extra margin once all expected reports have been taken.
    localparam int SETTLE_CYCLES  = 10;

    logic clk;
    logic rst_n;

    cfv_byte_if   frame_if ();
    cfv_report_if report_if ();

    checksum_frame_verifier u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame_if),
        .report (report_if)
    );

    // Queue of reports the block owes us, oldest first.
    cfv_pkg::cfv_result_t expected_reports[$];

    int bytes_sent  = 0;
    int error_count = 0;
    int stall_left  = 0;
    bit idle_on     = 1'b1;

    // Shadow of the frame state, advanced once per accepted byte request.
    logic [2:0]  hdr_taken   = '0;
    logic [15:0] len_field   = '0;
    logic [15:0] sum_field   = '0;
    logic [15:0] word_sum    = '0;
    logic [15:0] bytes_taken = '0;
    logic [7:0]  low_byte    = '0;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // Hard stop in case the block hangs or drops a report.
    initial
    begin
        #1_000_000;
        $display("FAILURE");
        $finish;
    end

    // 16-bit end-around add: anything past 0xffff wraps back in as +1.
    function automatic logic [15:0] wrap_add(input logic [15:0] a, input logic [15:0] b);
        int unsigned t;
        t = a + b;
        if (t > 32'h0000_ffff)
        begin
            t = t - 32'h0000_ffff;
        end
        return t[15:0];
    endfunction

    // Advances the shadow state by one byte; returns 1 with the report when
    // the byte closes a frame, either by completing it or by ending the buffer.
    function automatic bit frame_step(input logic [7:0] b, input logic last,
                                      output cfv_pkg::cfv_result_t res);
        logic        done;
        logic [15:0] total;
        done = 1'b0;
        res  = '0;
        if (hdr_taken < cfv_pkg::HEADER_BYTES)
        begin
            // Header: length low, length high, checksum low, checksum high.
            case (hdr_taken)
                3'd0:    len_field[7:0]  = b;
                3'd1:    len_field[15:8] = b;
                3'd2:    sum_field[7:0]  = b;
                default: sum_field[15:8] = b;
            endcase
            hdr_taken = hdr_taken + 3'd1;
            done = (hdr_taken == cfv_pkg::HEADER_BYTES) && (len_field == 16'd0);
        end
        else
        begin
            // Payload: an odd byte is the high half of the pending word.
            if (bytes_taken[0])
            begin
                word_sum = wrap_add(word_sum, {b, low_byte});
            end
            else
            begin
                low_byte = b;
            end
            bytes_taken = bytes_taken + 16'd1;
            done = (bytes_taken == len_field);
        end

        if (!done && !last)
        begin
            return 1'b0;
        end

        // A dangling low byte is summed with a zero high byte.
        total = bytes_taken[0] ? wrap_add(word_sum, {8'h00, low_byte}) : word_sum;
        res.computed_checksum = ~total;
        res.frame_length      = len_field;
        if (!done)
        begin
            res.status = cfv_pkg::STATUS_SHORT;
        end
        else if (res.computed_checksum == sum_field)
        begin
            res.status = cfv_pkg::STATUS_OK;
        end
        else
        begin
            res.status = cfv_pkg::STATUS_BAD_SUM;
        end

        // Every report sends the block back to waiting for a header.
        hdr_taken   = '0;
        len_field   = '0;
        sum_field   = '0;
        word_sum    = '0;
        bytes_taken = '0;
        low_byte    = '0;
        return 1'b1;
    endfunction

    // Correct header checksum for a payload, for building well-formed frames.
    function automatic logic [15:0] payload_checksum(input byte_q_t pl);
        int unsigned acc;
        acc = 0;
        for (int i = 0; i < pl.size(); i += 2)
        begin
            acc += pl[i];
            if (i + 1 < pl.size())
            begin
                acc += pl[i + 1] << 8;
            end
        end
        while (acc > 32'h0000_ffff)
        begin
            acc = (acc & 32'h0000_ffff) + (acc >> 16);
        end
        return ~acc[15:0];
    endfunction

    // One byte request: optional idle burst, then hold valid until accepted.
    // valid is lowered only when a gap starts, never in the step it is raised.
    task automatic send_byte(input logic [7:0] b, input logic last);
        cfv_pkg::cfv_result_t res;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            frame_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        frame_if.valid      <= 1'b1;
        frame_if.data_byte  <= b;
        frame_if.buffer_end <= last;
        do
        begin
            @(posedge clk);
        end
        while (!frame_if.ready);
        if (frame_step(b, last, res))
        begin
            expected_reports.push_back(res);
        end
        bytes_sent++;
    endtask

    // Header then payload; buffer_end goes on byte index cut, and nothing
    // after it is sent. cut < 0 means the buffer does not end in this frame.
    task automatic send_frame(input logic [15:0] len, input logic [15:0] chk,
                              input byte_q_t pl, input int cut);
        byte_q_t stream;
        stream = {len[7:0], len[15:8], chk[7:0], chk[15:8]};
        foreach (pl[i])
        begin
            stream.push_back(pl[i]);
        end
        for (int i = 0; i < stream.size(); i++)
        begin
            send_byte(stream[i], i == cut);
            if (i == cut)
            begin
                break;
            end
        end
    endtask

    // Zero-length frames close on the fourth header byte, sum 0xffff.
    // The second one also carries buffer_end there: still a complete frame.
    task automatic test_empty_payload();
        byte_q_t none;
        send_frame(16'h0000, 16'hffff, none, -1);
        send_frame(16'h0000, 16'h1234, none, 3);
    endtask

    // Buffer running out inside the header, and inside a very long payload
    // after an odd number of bytes (padded partial sum, full length shown).
    task automatic test_buffer_end_early();
        byte_q_t pl;
        send_byte(8'hff, 1'b1);
        pl = {8'ha5, 8'h5a, 8'h01};
        send_frame(16'hffff, 16'h0000, pl, 6);
    endtask

    // Odd-length payload with the right checksum, extreme byte values.
    task automatic test_checked_payload();
        byte_q_t pl;
        pl = {8'hff, 8'h00, 8'h80};
        send_frame(16'd3, payload_checksum(pl), pl, -1);
    endtask

    // Mostly well-formed frames with random content, plus truncated frames
    // and raw noise. Noise always ends on buffer_end so the next frame lines up.
    task automatic test_random_traffic();
        byte_q_t     pl;
        int          start;
        int          pick;
        int          len;
        int          n;
        logic [15:0] chk;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES)
        begin
            idle_on = (bytes_sent - start) < CALM_FROM;
            pick = $urandom_range(0, 99);
            pl.delete();
            if (pick < 70)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 200)
                                                  : $urandom_range(0, 24);
                repeat (len) pl.push_back(8'($urandom));
                chk = ($urandom_range(0, 6) == 0) ? 16'($urandom) : payload_checksum(pl);
                // Sometimes the closing byte is also the buffer's last.
                send_frame(16'(len), chk, pl, ($urandom_range(0, 3) == 0) ? len + 3 : -1);
            end
            else if (pick < 85)
            begin
                len = $urandom_range(1, 60);
                repeat (len) pl.push_back(8'($urandom));
                send_frame(16'(len), payload_checksum(pl), pl, $urandom_range(0, len + 2));
            end
            else
            begin
                n = $urandom_range(1, 30);
                for (int k = 0; k < n; k++)
                begin
                    send_byte(8'($urandom), (k == n - 1) || ($urandom_range(0, 7) == 0));
                end
            end
        end
    endtask

    // Report side: ready with random stall bursts while idling is on.
    initial
    begin
        report_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                report_if.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 8) - 1;
                report_if.ready <= 1'b0;
            end
            else
            begin
                report_if.ready <= 1'b1;
            end
        end
    end

    // Each accepted report is matched against the oldest expectation.
    always @(posedge clk)
    begin : report_check
        cfv_pkg::cfv_result_t want;
        if (rst_n && report_if.valid && report_if.ready)
        begin
            if (expected_reports.size() == 0)
            begin
                $display("%0t: unexpected report status=%0d sum=%h len=%h", $realtime,
                         report_if.status, report_if.computed_checksum,
                         report_if.frame_length);
                error_count++;
            end
            else
            begin
                want = expected_reports.pop_front();
                if (report_if.status !== want.status)
                begin
                    $display("%0t: status expected %0d got %0d", $realtime,
                             want.status, report_if.status);
                    error_count++;
                end
                if (report_if.computed_checksum !== want.computed_checksum)
                begin
                    $display("%0t: computed_checksum expected %h got %h", $realtime,
                             want.computed_checksum, report_if.computed_checksum);
                    error_count++;
                end
                if (report_if.frame_length !== want.frame_length)
                begin
                    $display("%0t: frame_length expected %h got %h", $realtime,
                             want.frame_length, report_if.frame_length);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        frame_if.valid      = 1'b0;
        frame_if.data_byte  = 8'h00;
        frame_if.buffer_end = 1'b0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_payload();
        test_buffer_end_early();
        test_checked_payload();
        test_random_traffic();

        frame_if.valid <= 1'b0;
        while (expected_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
